// ===== sv/tepba_pkg.sv =====
package tepba_pkg;

    localparam int WORD_W  = 64;
    localparam int POS_W   = 6;
    localparam int ADDR_W  = 40;
    localparam int XADDR_W = 42;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam int REG_IDX_BIT = 3;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 12;
    localparam int NUSE_W   = 13;
    localparam int TUSE_W   = 11;

    localparam int DEF_NORMAL_PAGES    = 4096;
    localparam int DEF_TABLE_PAGES     = 1024;
    localparam int DEF_PAGE_BITS       = 12;
    localparam int DEF_TABLE_PAGE_BITS = 12;
    localparam int DEF_MAX_BATCH       = 16;

    localparam logic [ADDR_W-1:0] BASE_RESET = 40'd0;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 40'd16777216;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_NORMAL = 2'd0,
        OP_FREE_NORMAL  = 2'd1,
        OP_ALLOC_TABLE  = 2'd2,
        OP_FREE_TABLE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_t;

    typedef enum logic {
        REG_REGION_BASE = 1'b0,
        REG_REGION_TOP  = 1'b1
    } reg_idx_t;

endpackage

// ===== sv/tepba_bmap.sv =====
module tepba_bmap #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [tepba_pkg::WORD_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [tepba_pkg::WORD_W-1:0] wr_data
);

    logic [tepba_pkg::WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             vld_reg;
    logic [tepba_pkg::WORD_W-1:0] rdata_reg;
    logic                         rvld_reg;

    // entries never written read as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

// ===== sv/two_ended_page_bitmap_allocator.sv =====
// Page allocator over one region: normal pages from region_base upward, table pages from
// region_top downward, each tracked in a bitmap memory of 64-bit words. One request is
// handled at a time; req_ready is high only while the sequencer is idle. A normal
// allocation of N pages scans the normal bitmap one word per cycle while the word holds no
// free page, taking each free page it finds, then does a read-modify-write per page and
// emits one result beat per page. A table allocation scans the table bitmap for one page.
// A free reads the word, clears the bit and rescans the bitmap from its top word downward
// for the new mark. Each bitmap memory has a single read port. The last result of each
// request carries last = 1; the block takes the next request while that beat still waits
// on rsp_ready.
module two_ended_page_bitmap_allocator #(
    parameter int NORMAL_PAGES    = tepba_pkg::DEF_NORMAL_PAGES,
    parameter int TABLE_PAGES     = tepba_pkg::DEF_TABLE_PAGES,
    parameter int PAGE_BITS       = tepba_pkg::DEF_PAGE_BITS,
    parameter int TABLE_PAGE_BITS = tepba_pkg::DEF_TABLE_PAGE_BITS,
    parameter int MAX_BATCH       = tepba_pkg::DEF_MAX_BATCH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tepba_pkg::PADDR_W-1:0]  paddr,
    input  logic [tepba_pkg::PDATA_W-1:0]  pwdata,
    output logic [tepba_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [tepba_pkg::OP_W-1:0]     operation,
    input  logic [tepba_pkg::COUNT_W-1:0]  page_count,
    input  logic [tepba_pkg::ADDR_W-1:0]   page_addr,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [tepba_pkg::STATUS_W-1:0] status,
    output logic [tepba_pkg::ADDR_W-1:0]   out_addr,
    output logic [tepba_pkg::INDEX_W-1:0]  out_index,
    output logic [tepba_pkg::NUSE_W-1:0]   normal_in_use,
    output logic [tepba_pkg::TUSE_W-1:0]   table_in_use,
    output logic                           last
);

    localparam int XW   = tepba_pkg::XADDR_W;
    localparam int AW40 = tepba_pkg::ADDR_W;
    localparam int DW   = tepba_pkg::WORD_W;
    localparam int NW   = (NORMAL_PAGES + 63) / 64;
    localparam int TW   = (TABLE_PAGES + 63) / 64;
    localparam int NAW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int TAW  = (TW > 1) ? $clog2(TW) : 1;
    localparam int MW   = (NW > TW) ? NW : TW;
    localparam int WW   = $clog2(MW + 1);
    localparam int PIW  = WW + tepba_pkg::POS_W;
    localparam int CW   = PIW + 1;
    localparam int NCW  = $clog2(NORMAL_PAGES + 1);
    localparam int TCW  = $clog2(TABLE_PAGES + 1);
    localparam int BW   = $clog2(MAX_BATCH + 1);
    localparam int RIW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int NREM = NORMAL_PAGES % 64;
    localparam int TREM = TABLE_PAGES % 64;
    localparam logic [DW-1:0] NTAIL = (NREM == 0) ? '0 : ~((64'd1 << NREM) - 64'd1);
    localparam logic [DW-1:0] TTAIL = (TREM == 0) ? '0 : ~((64'd1 << TREM) - 64'd1);
    localparam logic [WW-1:0] NTOP_W = WW'(NW - 1);
    localparam logic [WW-1:0] TTOP_W = WW'(TW - 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_PREP   = 12'b000000000010,
        S_DISP   = 12'b000000000100,
        S_SSTART = 12'b000000001000,
        S_SCAN   = 12'b000000010000,
        S_NCHK   = 12'b000000100000,
        S_TCHK   = 12'b000001000000,
        S_CRD    = 12'b000010000000,
        S_CWR    = 12'b000100000000,
        S_EMIT   = 12'b001000000000,
        S_FRD    = 12'b010000000000,
        S_FCHK   = 12'b100000000000
    } state_t;

    // the mark rescan after a free runs through these sub-phases of the idle state
    typedef enum logic [2:0] {
        P_NONE  = 3'b001,
        P_HPS   = 3'b010,
        P_HPSCN = 3'b100
    } phase_t;

    function automatic logic [5:0] lsb_pos(input logic [DW-1:0] v);
        logic [DW-1:0] x;
        logic [5:0]    r;
        x = v;
        r = '0;
        for (int k = 5; k >= 0; k--)
        begin
            if ((x & ((64'd1 << (1 << k)) - 64'd1)) == '0)
            begin
                r[k] = 1'b1;
                x = x >> (1 << k);
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] msb_pos(input logic [DW-1:0] v);
        logic [DW-1:0] x;
        logic [5:0]    r;
        x = v;
        r = '0;
        for (int k = 5; k >= 0; k--)
        begin
            if ((x >> (1 << k)) != '0)
            begin
                r[k] = 1'b1;
                x = x >> (1 << k);
            end
        end
        return r;
    endfunction

    state_t                 state_reg;
    phase_t                 phase_reg;
    logic                   resp_pend_reg;
    tepba_pkg::op_t         op_reg;
    logic [tepba_pkg::COUNT_W-1:0] cnt_reg;
    logic [AW40-1:0]        pa_reg;
    logic [AW40-1:0]        base_reg;
    logic [AW40-1:0]        top_reg;
    logic [XW-1:0]          hi_reg;
    logic [XW-1:0]          lo_reg;
    logic [XW-1:0]          limit_reg;
    logic [XW-1:0]          pfn_reg;
    logic                   sel_reg;
    logic [WW-1:0]          w_reg;
    logic [DW-1:0]          taken_reg;
    logic [BW-1:0]          got_reg;
    logic [BW-1:0]          ptr_reg;
    logic [BW-1:0]          need_reg;
    logic [PIW-1:0]         rec_reg [MAX_BATCH];
    logic [PIW-1:0]         last_rec_reg;
    logic [NCW-1:0]         nused_reg;
    logic [TCW-1:0]         tused_reg;
    logic [NCW-1:0]         nhp_reg;
    logic [TCW-1:0]         tlp_reg;
    logic [tepba_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [AW40-1:0]        rsp_addr_reg;
    logic [PIW-1:0]         rsp_idx_reg;
    logic                   out_valid_reg;
    logic [tepba_pkg::STATUS_W-1:0] out_status_reg;
    logic [AW40-1:0]        out_addr_reg;
    logic [tepba_pkg::INDEX_W-1:0]  out_index_reg;
    logic [NCW-1:0]         out_nuse_reg;
    logic [TCW-1:0]         out_tuse_reg;
    logic                   out_last_reg;

    logic                   rd_en;
    logic [WW-1:0]          rd_addr;
    logic                   wr_en;
    logic [WW-1:0]          wr_addr;
    logic [DW-1:0]          wr_data;
    logic [DW-1:0]          n_rdata;
    logic [DW-1:0]          t_rdata;
    logic [DW-1:0]          rdata;

    logic                   cfg_wr;
    logic                   out_load;
    logic [XW-1:0]          base_x;
    logic [XW-1:0]          top_x;
    logic [XW-1:0]          pa_x;
    logic [XW-1:0]          tbytes;
    logic [XW-1:0]          nlimit;
    logic [XW-1:0]          tlimit;
    logic                   nfree_bad;
    logic                   tfree_bad;
    logic [XW-1:0]          nbits;
    logic [XW-1:0]          cur_start;
    logic [XW-1:0]          nxt_start;
    logic                   cur_ok;
    logic                   nxt_ok;
    logic [WW-1:0]          w_inc;
    logic [DW-1:0]          tail;
    logic [DW-1:0]          free_bits;
    logic [5:0]             pos;
    logic [PIW-1:0]         found_idx;
    logic [PIW-1:0]         rec_cur;
    logic [XW-1:0]          last_addr;
    logic [XW-1:0]          tneed;
    logic [CW-1:0]          last_p1;
    logic [CW-1:0]          mark;
    logic [5:0]             pfn_pos;
    logic [WW-1:0]          pfn_word;
    logic                   got_done;
    logic                   ptr_done;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[tepba_pkg::REG_IDX_BIT] == tepba_pkg::REG_REGION_TOP)
                   ? tepba_pkg::PDATA_W'(top_reg) : tepba_pkg::PDATA_W'(base_reg);

    // no new request while a free rescans its mark or a single beat still waits to load
    assign req_ready = (state_reg == S_IDLE) && (phase_reg == P_NONE) && !resp_pend_reg;
    assign out_load  = !out_valid_reg || rsp_ready;

    assign base_x = XW'(base_reg);
    assign top_x  = XW'(top_reg);
    assign pa_x   = XW'(pa_reg);
    assign tbytes = XW'(tlp_reg) << TABLE_PAGE_BITS;

    assign nlimit = (lo_reg > base_x) ? ((lo_reg - base_x) >> PAGE_BITS) : '0;
    assign tlimit = (hi_reg < top_x) ? ((top_x - hi_reg) >> TABLE_PAGE_BITS) : '0;
    assign nfree_bad = (pa_x < base_x) || (pa_x >= hi_reg) || (pa_x >= lo_reg)
                    || (pa_x >= top_x);
    assign tfree_bad = (pa_x < base_x) || (pa_x >= top_x) || (pa_x < lo_reg);

    // a word is scanned only while its first page lies below the limit and the map end
    assign nbits     = sel_reg ? XW'(TABLE_PAGES) : XW'(NORMAL_PAGES);
    assign w_inc     = w_reg + WW'(1);
    assign cur_start = XW'({w_reg, 6'd0});
    assign nxt_start = XW'({w_inc, 6'd0});
    assign cur_ok    = (cur_start < limit_reg) && (cur_start < nbits);
    assign nxt_ok    = (nxt_start < limit_reg) && (nxt_start < nbits)
                    && (w_reg != {WW{1'b1}});

    always_comb
    begin
        tail = '0;
        if (!sel_reg && (w_reg == NTOP_W))
        begin
            tail = NTAIL;
        end
        else if (sel_reg && (w_reg == TTOP_W))
        begin
            tail = TTAIL;
        end
    end

    assign rdata     = sel_reg ? t_rdata : n_rdata;
    assign free_bits = ~(rdata | taken_reg | tail);
    assign pos       = lsb_pos(free_bits);
    assign found_idx = {w_reg, pos};
    assign rec_cur   = rec_reg[ptr_reg[RIW-1:0]];
    assign last_addr = base_x + (XW'(last_rec_reg) << PAGE_BITS);
    assign tneed     = (XW'(last_rec_reg) + XW'(1)) << TABLE_PAGE_BITS;
    assign last_p1   = CW'(last_rec_reg) + CW'(1);
    assign mark      = (rdata != '0) ? (CW'({w_reg, msb_pos(rdata)}) + CW'(1)) : '0;
    assign pfn_pos   = pfn_reg[5:0];
    assign pfn_word  = WW'(pfn_reg[XW-1:6]);
    assign got_done  = ((got_reg + BW'(1)) == need_reg);
    assign ptr_done  = ((ptr_reg + BW'(1)) == need_reg);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = w_reg;
        wr_en   = 1'b0;
        wr_addr = rec_cur[PIW-1:6];
        wr_data = rdata | (64'd1 << rec_cur[5:0]);
        unique case (state_reg)
            S_SSTART:
            begin
                rd_en = cur_ok;
            end
            S_SCAN:
            begin
                rd_en   = (free_bits == '0) && nxt_ok;
                rd_addr = w_inc;
            end
            S_CRD:
            begin
                rd_en   = 1'b1;
                rd_addr = rec_cur[PIW-1:6];
            end
            S_CWR:
            begin
                wr_en = 1'b1;
            end
            S_FRD:
            begin
                rd_en   = 1'b1;
                rd_addr = pfn_word;
            end
            S_FCHK:
            begin
                wr_en   = rdata[pfn_pos];
                wr_addr = pfn_word;
                wr_data = rdata & ~(64'd1 << pfn_pos);
            end
            S_IDLE:
            begin
                if (phase_reg == P_HPS)
                begin
                    rd_en   = 1'b1;
                    rd_addr = sel_reg ? TTOP_W : NTOP_W;
                end
                else if (phase_reg == P_HPSCN)
                begin
                    rd_en   = (rdata == '0) && (w_reg != '0);
                    rd_addr = w_reg - WW'(1);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    tepba_bmap #(
        .DEPTH (NW),
        .AW    (NAW)
    ) u_normal_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en && !sel_reg),
        .rd_addr (rd_addr[NAW-1:0]),
        .rd_data (n_rdata),
        .wr_en   (wr_en && !sel_reg),
        .wr_addr (wr_addr[NAW-1:0]),
        .wr_data (wr_data)
    );

    tepba_bmap #(
        .DEPTH (TW),
        .AW    (TAW)
    ) u_table_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en && sel_reg),
        .rd_addr (rd_addr[TAW-1:0]),
        .rd_data (t_rdata),
        .wr_en   (wr_en && sel_reg),
        .wr_addr (wr_addr[TAW-1:0]),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= tepba_pkg::BASE_RESET;
            top_reg  <= tepba_pkg::TOP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[tepba_pkg::REG_IDX_BIT] == tepba_pkg::REG_REGION_TOP)
            begin
                top_reg <= pwdata[AW40-1:0];
            end
            else
            begin
                base_reg <= pwdata[AW40-1:0];
            end
        end
    end

    // records of pages found by the current scan
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && (free_bits != '0))
        begin
            rec_reg[got_reg[RIW-1:0]] <= found_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= P_NONE;
            resp_pend_reg  <= 1'b0;
            op_reg         <= tepba_pkg::OP_ALLOC_NORMAL;
            cnt_reg        <= '0;
            pa_reg         <= '0;
            hi_reg         <= '0;
            lo_reg         <= '0;
            limit_reg      <= '0;
            pfn_reg        <= '0;
            sel_reg        <= 1'b0;
            w_reg          <= '0;
            taken_reg      <= '0;
            got_reg        <= '0;
            ptr_reg        <= '0;
            need_reg       <= '0;
            last_rec_reg   <= '0;
            nused_reg      <= '0;
            tused_reg      <= '0;
            nhp_reg        <= '0;
            tlp_reg        <= '0;
            rsp_status_reg <= tepba_pkg::ST_OK;
            rsp_addr_reg   <= '0;
            rsp_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_addr_reg   <= '0;
            out_index_reg  <= '0;
            out_nuse_reg   <= '0;
            out_tuse_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    // mark rescan after a free, then the single result beat
                    if (phase_reg == P_HPS)
                    begin
                        w_reg     <= sel_reg ? TTOP_W : NTOP_W;
                        phase_reg <= P_HPSCN;
                    end
                    else if (phase_reg == P_HPSCN)
                    begin
                        if ((rdata != '0) || (w_reg == '0))
                        begin
                            if (sel_reg)
                            begin
                                tlp_reg <= TCW'(mark);
                            end
                            else
                            begin
                                nhp_reg <= NCW'(mark);
                            end
                            phase_reg     <= P_NONE;
                            resp_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            w_reg <= w_reg - WW'(1);
                        end
                    end
                    else if (resp_pend_reg)
                    begin
                        if (out_load)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= rsp_status_reg;
                            out_addr_reg   <= rsp_addr_reg;
                            out_index_reg  <= tepba_pkg::INDEX_W'(rsp_idx_reg);
                            out_nuse_reg   <= nused_reg;
                            out_tuse_reg   <= tused_reg;
                            out_last_reg   <= 1'b1;
                            resp_pend_reg  <= 1'b0;
                        end
                    end
                    else if (req_valid)
                    begin
                        op_reg    <= tepba_pkg::op_t'(operation);
                        cnt_reg   <= page_count;
                        pa_reg    <= page_addr;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    hi_reg    <= base_x + (XW'(nhp_reg) << PAGE_BITS);
                    lo_reg    <= (tbytes > top_x) ? '0 : (top_x - tbytes);
                    state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    rsp_status_reg <= tepba_pkg::ST_OK;
                    rsp_addr_reg   <= '0;
                    rsp_idx_reg    <= '0;
                    w_reg          <= '0;
                    taken_reg      <= '0;
                    got_reg        <= '0;
                    ptr_reg        <= '0;
                    unique case (op_reg)
                        tepba_pkg::OP_ALLOC_NORMAL:
                        begin
                            sel_reg   <= 1'b0;
                            limit_reg <= nlimit;
                            need_reg  <= BW'(cnt_reg);
                            if (cnt_reg == '0)
                            begin
                                resp_pend_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else if (7'(cnt_reg) > 7'(MAX_BATCH))
                            begin
                                rsp_status_reg <= tepba_pkg::ST_NO_SPACE;
                                resp_pend_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_SSTART;
                            end
                        end
                        tepba_pkg::OP_ALLOC_TABLE:
                        begin
                            sel_reg   <= 1'b1;
                            limit_reg <= tlimit;
                            need_reg  <= BW'(1);
                            state_reg <= S_SSTART;
                        end
                        tepba_pkg::OP_FREE_NORMAL:
                        begin
                            sel_reg <= 1'b0;
                            pfn_reg <= (pa_x - base_x) >> PAGE_BITS;
                            if (nfree_bad)
                            begin
                                rsp_status_reg <= tepba_pkg::ST_BAD_ADDR;
                                resp_pend_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_FRD;
                            end
                        end
                        tepba_pkg::OP_FREE_TABLE:
                        begin
                            sel_reg <= 1'b1;
                            pfn_reg <= (top_x - XW'(1) - pa_x) >> TABLE_PAGE_BITS;
                            if (tfree_bad)
                            begin
                                rsp_status_reg <= tepba_pkg::ST_BAD_ADDR;
                                resp_pend_reg  <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_FRD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SSTART:
                begin
                    if (cur_ok)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        rsp_status_reg <= tepba_pkg::ST_NO_SPACE;
                        resp_pend_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (free_bits != '0)
                    begin
                        last_rec_reg <= found_idx;
                        taken_reg    <= taken_reg | (64'd1 << pos);
                        got_reg      <= got_reg + BW'(1);
                        if (got_done)
                        begin
                            state_reg <= sel_reg ? S_TCHK : S_NCHK;
                        end
                    end
                    else if (nxt_ok)
                    begin
                        w_reg     <= w_inc;
                        taken_reg <= '0;
                    end
                    else
                    begin
                        rsp_status_reg <= tepba_pkg::ST_NO_SPACE;
                        resp_pend_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_NCHK:
                begin
                    if (last_addr >= lo_reg)
                    begin
                        rsp_status_reg <= tepba_pkg::ST_NO_SPACE;
                        resp_pend_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CRD;
                    end
                end
                S_TCHK:
                begin
                    if ((tneed > top_x) || ((top_x - tneed) < hi_reg))
                    begin
                        rsp_status_reg <= tepba_pkg::ST_NO_SPACE;
                        resp_pend_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        rsp_addr_reg <= AW40'(top_x - tneed);
                        rsp_idx_reg  <= last_rec_reg;
                        state_reg    <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CWR;
                end
                S_CWR:
                begin
                    if (ptr_done)
                    begin
                        ptr_reg <= '0;
                        if (sel_reg)
                        begin
                            tused_reg <= tused_reg + TCW'(1);
                            if (last_p1 > CW'(tlp_reg))
                            begin
                                tlp_reg <= TCW'(last_p1);
                            end
                            resp_pend_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            nused_reg <= nused_reg + NCW'(need_reg);
                            if (last_p1 > CW'(nhp_reg))
                            begin
                                nhp_reg <= NCW'(last_p1);
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + BW'(1);
                        state_reg <= S_CRD;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= tepba_pkg::ST_OK;
                        out_addr_reg   <= AW40'(base_x + (XW'(rec_cur) << PAGE_BITS));
                        out_index_reg  <= tepba_pkg::INDEX_W'(rec_cur);
                        out_nuse_reg   <= nused_reg;
                        out_tuse_reg   <= tused_reg;
                        out_last_reg   <= ptr_done;
                        ptr_reg        <= ptr_reg + BW'(1);
                        if (ptr_done)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FRD:
                begin
                    if (pfn_reg >= (sel_reg ? XW'(TABLE_PAGES) : XW'(NORMAL_PAGES)))
                    begin
                        rsp_status_reg <= tepba_pkg::ST_BAD_ADDR;
                        resp_pend_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FCHK;
                    end
                end
                S_FCHK:
                begin
                    state_reg <= S_IDLE;
                    if (!rdata[pfn_pos])
                    begin
                        rsp_status_reg <= tepba_pkg::ST_BAD_ADDR;
                        resp_pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        rsp_idx_reg <= PIW'(pfn_reg);
                        phase_reg   <= P_HPS;
                        if (sel_reg)
                        begin
                            tused_reg <= tused_reg - TCW'(1);
                        end
                        else
                        begin
                            nused_reg <= nused_reg - NCW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign out_addr      = out_addr_reg;
    assign out_index     = out_index_reg;
    assign normal_in_use = tepba_pkg::NUSE_W'(out_nuse_reg);
    assign table_in_use  = tepba_pkg::TUSE_W'(out_tuse_reg);
    assign last          = out_last_reg;

endmodule
